// ===== rtl/bitonic_array_search_defines.svh =====
// assertion helpers used by the rtl
`ifndef BITONIC_ARRAY_SEARCH_DEFINES_SVH
`define BITONIC_ARRAY_SEARCH_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bas assertion failed");

// next-cycle implication, disabled while reset is low
`define BAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bas assertion failed");

`endif

// ===== rtl/bas_pkg.sv =====
package bas_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_BITS   = 32;
    localparam int ADDR_W       = 10;
    localparam int CNT_W        = 11;
    localparam int POS_W        = CNT_W + 1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [ADDR_W-1:0]         address;
        logic signed [31:0]        value;
    } t_req;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] index;
    } t_rsp;

endpackage

// ===== rtl/bitonic_array_search.sv =====
// channel   | direction | valid        | stall        | payload
// request   | in        | i_req_valid  | o_req_stall  | i_req (kind, address, value)
// response  | out       | o_rsp_valid  | i_rsp_stall  | o_rsp (found, index)
// config    | in        | i_cfg_we     | none         | i_cfg_data (element_count)
//
// a write request completes at its accepting edge, where the store is written
// a query runs an outer bisection: each outer step reads mid and mid+1 and
//   compares slope and goal; a goal below mid sets up a side search by reading
//   both side ends, then bisects that side one read at a time, all through the
//   single store read port with registered read data; a query runs longest when
//   the goal sends every outer step into a side search that misses
// one request is in work at a time; a finished response sits in an output
//   register so the next request is taken while it waits
// synchronous active-low reset clears control and sets element_count to 1;
//   the store has no reset and no clearing pass

`include "bitonic_array_search_defines.svh"

module bitonic_array_search
    import bas_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data
);

    // one-hot sequencer states
    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,  // waiting for a request
        ST_MMID = 10'b00_0000_0010,  // outer bisection: issue read of mid
        ST_MNXT = 10'b00_0000_0100,  // capture mid, issue read of mid+1
        ST_MCMP = 10'b00_0000_1000,  // slope and goal compare
        ST_SLO  = 10'b00_0001_0000,  // side search: read low end
        ST_SHI  = 10'b00_0010_0000,  // side search: read high end
        ST_SDIR = 10'b00_0100_0000,  // side search: direction from end values
        ST_SMID = 10'b00_1000_0000,  // side search: issue read of mid
        ST_SCMP = 10'b01_0000_0000,  // side search: compare
        ST_OUT  = 10'b10_0000_0000   // hand result to the output register
    } t_state;

    // element store, one write and one registered read port
    logic [VALUE_BITS-1:0] r_mem [MAX_ELEMENTS];
    logic [VALUE_BITS-1:0] r_rdata;
    logic [ADDR_W-1:0]     rd_addr;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_n, n_n;
    logic signed [VALUE_BITS-1:0] r_goal, n_goal;
    logic signed [POS_W-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic signed [POS_W-1:0] r_slo, n_slo, r_shi, n_shi, r_smid, n_smid;
    logic signed [VALUE_BITS-1:0] r_kmid, n_kmid, r_klo, n_klo;
    logic                    r_up, n_up, r_rising, n_rising;
    logic                    r_found, n_found;
    logic [ADDR_W-1:0]       r_idx, n_idx;
    logic                    r_rsp_valid, n_rsp_valid;
    t_rsp                    r_rsp, n_rsp;

    logic                    req_acc;
    logic signed [POS_W-1:0] n_s;
    logic signed [POS_W-1:0] mid_c, smid_c, mid_p1, mid_m1;
    logic signed [VALUE_BITS-1:0] rd_s;
    logic                    up_c;
    logic [CNT_W-1:0]        cnt_clamped;

    assign o_req_stall = (r_state != ST_IDLE);
    assign req_acc     = i_req_valid && !o_req_stall;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // working count, clamped to the store depth
    assign cnt_clamped = (r_count > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : r_count;

    assign n_s    = $signed({1'b0, r_n});
    assign mid_c  = (r_lo + r_hi) >>> 1;
    assign smid_c = (r_slo + r_shi) >>> 1;
    assign mid_p1 = r_mid + POS_W'(1);
    assign mid_m1 = r_mid - POS_W'(1);
    assign rd_s   = $signed(r_rdata);
    // last valid index counts as falling
    assign up_c   = (mid_p1 < n_s) && (r_kmid < rd_s);

    // store read address per state
    always_comb begin
        unique case (r_state)
            ST_MMID: rd_addr = mid_c[ADDR_W-1:0];
            ST_MNXT: rd_addr = mid_p1[ADDR_W-1:0];
            ST_SLO:  rd_addr = r_slo[ADDR_W-1:0];
            ST_SHI:  rd_addr = r_shi[ADDR_W-1:0];
            ST_SMID: rd_addr = smid_c[ADDR_W-1:0];
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (req_acc && (i_req.kind == KIND_WRITE)) begin
            r_mem[i_req.address] <= i_req.value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_goal      = r_goal;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_slo       = r_slo;
        n_shi       = r_shi;
        n_smid      = r_smid;
        n_kmid      = r_kmid;
        n_klo       = r_klo;
        n_up        = r_up;
        n_rising    = r_rising;
        n_found     = r_found;
        n_idx       = r_idx;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        n_rsp       = r_rsp;

        unique case (r_state)
            ST_IDLE: begin
                // writes finish at the accepting edge; queries start a search
                if (req_acc && (i_req.kind == KIND_QUERY)) begin
                    n_n     = cnt_clamped;
                    n_goal  = i_req.value;
                    n_lo    = '0;
                    n_hi    = $signed({1'b0, cnt_clamped}) - POS_W'(1);
                    n_state = ST_MMID;
                end
            end
            ST_MMID: begin
                if (r_lo > r_hi) begin
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_state = ST_OUT;
                end else begin
                    n_mid   = mid_c;
                    n_state = ST_MNXT;
                end
            end
            ST_MNXT: begin
                n_kmid  = rd_s;
                n_state = ST_MCMP;
            end
            ST_MCMP: begin
                priority if (r_kmid < r_goal) begin
                    if (up_c) begin
                        n_lo = mid_p1;
                    end else begin
                        n_hi = mid_m1;
                    end
                    n_state = ST_MMID;
                end else if (r_kmid > r_goal) begin
                    // goal below mid: search the monotone side first
                    n_up = up_c;
                    if (up_c) begin
                        n_slo = '0;
                        n_shi = mid_m1;
                    end else begin
                        n_slo = mid_p1;
                        n_shi = n_s - POS_W'(1);
                    end
                    n_state = ST_SLO;
                end else begin
                    n_found = 1'b1;
                    n_idx   = r_mid[ADDR_W-1:0];
                    n_state = ST_OUT;
                end
            end
            ST_SLO: begin
                if (r_slo > r_shi) begin
                    // empty side: narrow the outer range
                    if (r_up) begin
                        n_lo = mid_p1;
                    end else begin
                        n_hi = mid_m1;
                    end
                    n_state = ST_MMID;
                end else begin
                    n_state = ST_SHI;
                end
            end
            ST_SHI: begin
                n_klo   = rd_s;
                n_state = ST_SDIR;
            end
            ST_SDIR: begin
                n_rising = (r_klo < rd_s);
                n_state  = ST_SMID;
            end
            ST_SMID: begin
                if (r_slo > r_shi) begin
                    if (r_up) begin
                        n_lo = mid_p1;
                    end else begin
                        n_hi = mid_m1;
                    end
                    n_state = ST_MMID;
                end else begin
                    n_smid  = smid_c;
                    n_state = ST_SCMP;
                end
            end
            ST_SCMP: begin
                if (rd_s == r_goal) begin
                    n_found = 1'b1;
                    n_idx   = r_smid[ADDR_W-1:0];
                    n_state = ST_OUT;
                end else begin
                    if ((rd_s < r_goal) == r_rising) begin
                        n_slo = r_smid + POS_W'(1);
                    end else begin
                        n_shi = r_smid - POS_W'(1);
                    end
                    n_state = ST_SMID;
                end
            end
            ST_OUT: begin
                // load the output register once it is free or being taken
                if (!r_rsp_valid || !i_rsp_stall) begin
                    n_rsp_valid = 1'b1;
                    n_rsp.found = r_found;
                    n_rsp.index = r_idx;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
            r_count     <= CNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_goal   <= n_goal;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_slo    <= n_slo;
        r_shi    <= n_shi;
        r_smid   <= n_smid;
        r_kmid   <= n_kmid;
        r_klo    <= n_klo;
        r_up     <= n_up;
        r_rising <= n_rising;
        r_found  <= n_found;
        r_idx    <= n_idx;
        r_rsp    <= n_rsp;
    end

    // a query always enters the outer bisection next
    `BAS_ASSERT_NEXT(a_query_starts, i_clk, i_rst_n,
        req_acc && (i_req.kind == KIND_QUERY), r_state == ST_MMID)
    // a write never starts the sequencer
    `BAS_ASSERT_NEXT(a_write_stays_idle, i_clk, i_rst_n,
        req_acc && (i_req.kind == KIND_WRITE), r_state == ST_IDLE)
    // outer range stays inside the valid elements
    `BAS_ASSERT_NOW(a_outer_bounds, i_clk, i_rst_n,
        (r_state == ST_MMID) && (r_lo <= r_hi), (r_lo >= 0) && (r_hi < n_s))
    // side range stays inside the valid elements
    `BAS_ASSERT_NOW(a_side_bounds, i_clk, i_rst_n,
        (r_state == ST_SMID) && (r_slo <= r_shi), (r_slo >= 0) && (r_shi < n_s))

endmodule
